### hdl/h264fu_pkg.sv
package h264fu_pkg;

  localparam int NAL_LEN_W  = 16;
  localparam int MTU_W      = 14;
  localparam int TIME_W     = 32;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_USE_DECODE_TIME  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PACKET_BYTES = 2'd1;

  localparam logic [MTU_W-1:0] MTU_RESET   = 14'd1436;
  localparam logic [MTU_W-1:0] MTU_MIN     = 14'd1100;
  localparam logic [MTU_W-1:0] PREFIX_LEN  = 14'd2;
  localparam logic [4:0]       FU_A_TYPE   = 5'd28;

  typedef struct packed {
    logic load;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic last;
  } dp_status_t;

endpackage

### hdl/h264fu_ctrl.sv
module h264fu_ctrl
  import h264fu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RUN  = 1'b1;

  logic state;
  logic state_next;
  logic out_valid_next;
  logic slot_free;

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE);
  assign cmd.load  = in_valid && in_ready;
  assign cmd.emit  = (state == S_RUN) && slot_free;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.load) state_next = S_RUN;
      end
      S_RUN: begin
        if (cmd.emit && status.last) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.emit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

### hdl/h264fu_dp.sv
module h264fu_dp
  import h264fu_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  ctrl_cmd_t            cmd,
  output dp_status_t           status,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [MTU_W-1:0]     cfg_data,
  input  logic [7:0]           nal_header,
  input  logic [NAL_LEN_W-1:0] nal_length,
  input  logic                 last_of_frame,
  input  logic [TIME_W-1:0]    decode_time,
  input  logic [TIME_W-1:0]    composition_offset,
  output logic                 prefix_present,
  output logic [7:0]           fu_indicator,
  output logic [7:0]           fu_header,
  output logic [NAL_LEN_W-1:0] nal_offset,
  output logic [NAL_LEN_W-1:0] nal_bytes,
  output logic [NAL_LEN_W-1:0] packet_bytes,
  output logic                 marker_bit,
  output logic [TIME_W-1:0]    rtp_timestamp,
  output logic                 last_packet
);

  logic                 use_decode_time;
  logic [MTU_W-1:0]     max_packet_bytes;

  logic [7:0]           held_header;
  logic [TIME_W-1:0]    held_timestamp;
  logic                 held_frame_end;
  logic                 fragmenting;
  logic                 first_frag;
  logic [NAL_LEN_W-1:0] read_offset;
  logic [NAL_LEN_W-1:0] bytes_remaining;
  logic [MTU_W-1:0]     chunk;

  logic [MTU_W-1:0]     mtu;
  logic                 frag_in;
  logic                 last_now;
  logic [NAL_LEN_W-1:0] chunk_ext;
  logic [NAL_LEN_W-1:0] nb;

  assign mtu       = (max_packet_bytes < MTU_MIN) ? MTU_MIN : max_packet_bytes;
  assign frag_in   = nal_length > {{(NAL_LEN_W-MTU_W){1'b0}}, mtu};
  assign chunk_ext = {{(NAL_LEN_W-MTU_W){1'b0}}, chunk};
  assign last_now  = !fragmenting || (bytes_remaining <= chunk_ext);
  assign nb        = last_now ? bytes_remaining : chunk_ext;
  assign status.last = last_now;

  always_ff @(posedge clk) begin
    if (rst) begin
      use_decode_time  <= 1'b0;
      max_packet_bytes <= MTU_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_USE_DECODE_TIME:  use_decode_time  <= cfg_data[0];
        CFG_MAX_PACKET_BYTES: max_packet_bytes <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fragmenting     <= 1'b0;
      first_frag      <= 1'b0;
      read_offset     <= '0;
      bytes_remaining <= '0;
    end else if (cmd.load) begin
      fragmenting     <= frag_in;
      first_frag      <= 1'b1;
      read_offset     <= frag_in ? NAL_LEN_W'(1) : '0;
      bytes_remaining <= frag_in ? nal_length - NAL_LEN_W'(1) : nal_length;
    end else if (cmd.emit) begin
      first_frag      <= 1'b0;
      read_offset     <= read_offset + chunk_ext;
      bytes_remaining <= bytes_remaining - chunk_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      held_header    <= nal_header;
      held_frame_end <= last_of_frame;
      held_timestamp <= use_decode_time ? decode_time : decode_time + composition_offset;
      chunk          <= mtu - PREFIX_LEN;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      prefix_present <= fragmenting;
      fu_indicator   <= fragmenting ? {held_header[7:5], FU_A_TYPE} : 8'd0;
      fu_header      <= fragmenting ? {first_frag, last_now, 1'b0, held_header[4:0]} : 8'd0;
      nal_offset     <= read_offset;
      nal_bytes      <= nb;
      packet_bytes   <= nb + (fragmenting ? {{(NAL_LEN_W-MTU_W){1'b0}}, PREFIX_LEN} : '0);
      marker_bit     <= last_now && held_frame_end;
      rtp_timestamp  <= held_timestamp;
      last_packet    <= last_now;
    end
  end

endmodule

### hdl/h264_rtp_fu_a_fragmenter.sv
// channel  direction  handshake              payload
// in       input      in_valid / in_ready    nal_header, nal_length, last_of_frame, times
// out      output     out_valid / out_ready  one packet descriptor per item
// cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A NAL unit is taken while the controller is idle, then its n descriptors (n = 1
// unfragmented, at most 60 fragments) leave one per cycle from the output register. The
// fragment loop of the controller emits them; the next NAL unit is taken once the last
// descriptor is registered. A stalled output holds the loop.
// Synchronous reset idles the controller and sets the packet limit to 1436 bytes.
module h264_rtp_fu_a_fragmenter
  import h264fu_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           nal_header,
  input  logic [NAL_LEN_W-1:0] nal_length,
  input  logic                 last_of_frame,
  input  logic [TIME_W-1:0]    decode_time,
  input  logic [TIME_W-1:0]    composition_offset,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 prefix_present,
  output logic [7:0]           fu_indicator,
  output logic [7:0]           fu_header,
  output logic [NAL_LEN_W-1:0] nal_offset,
  output logic [NAL_LEN_W-1:0] nal_bytes,
  output logic [NAL_LEN_W-1:0] packet_bytes,
  output logic                 marker_bit,
  output logic [TIME_W-1:0]    rtp_timestamp,
  output logic                 last_packet,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [MTU_W-1:0]     cfg_data
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  h264fu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  h264fu_dp u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .status             (status),
    .cfg_write          (cfg_valid && cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .nal_header         (nal_header),
    .nal_length         (nal_length),
    .last_of_frame      (last_of_frame),
    .decode_time        (decode_time),
    .composition_offset (composition_offset),
    .prefix_present     (prefix_present),
    .fu_indicator       (fu_indicator),
    .fu_header          (fu_header),
    .nal_offset         (nal_offset),
    .nal_bytes          (nal_bytes),
    .packet_bytes       (packet_bytes),
    .marker_bit         (marker_bit),
    .rtp_timestamp      (rtp_timestamp),
    .last_packet        (last_packet)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while previous NAL unit still in progress");

  a_unprefixed_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !prefix_present |-> last_packet)
    else $error("unfragmented packet not flagged last");

  a_marker_only_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && marker_bit |-> last_packet)
    else $error("marker on a non-final packet");

  a_end_bit_on_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && prefix_present |-> (fu_header[6] == last_packet))
    else $error("FU-A end bit disagrees with last packet flag");

endmodule

### bench/h264_rtp_fu_a_fragmenter_tb.sv
`timescale 1ns / 1ps

module h264_rtp_fu_a_fragmenter_tb;
  import h264fu_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam logic [7:0] FU_START = 8'h80;
  localparam logic [7:0] FU_END = 8'h40;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 2000;

  typedef struct {
    logic                 prefix;
    logic [7:0]           ind;
    logic [7:0]           hdr;
    logic [NAL_LEN_W-1:0] off;
    logic [NAL_LEN_W-1:0] nbytes;
    logic [NAL_LEN_W-1:0] pbytes;
    logic                 marker;
    logic [TIME_W-1:0]    ts;
    logic                 last;
  } packet_t;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  logic [7:0]           nal_header;
  logic [NAL_LEN_W-1:0] nal_length;
  logic                 last_of_frame;
  logic [TIME_W-1:0]    decode_time;
  logic [TIME_W-1:0]    composition_offset;
  logic                 out_valid;
  logic                 out_ready;
  logic                 prefix_present;
  logic [7:0]           fu_indicator;
  logic [7:0]           fu_header;
  logic [NAL_LEN_W-1:0] nal_offset;
  logic [NAL_LEN_W-1:0] nal_bytes;
  logic [NAL_LEN_W-1:0] packet_bytes;
  logic                 marker_bit;
  logic [TIME_W-1:0]    rtp_timestamp;
  logic                 last_packet;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [MTU_W-1:0]     cfg_data;

  packet_t packet_q[$];
  logic cfg_use_dt = 1'b0;
  logic [MTU_W-1:0] cfg_mtu = MTU_RESET;
  bit tx_idle = 1'b0;
  bit rx_idle = 1'b0;
  bit hold_req = 1'b0;
  int fail_count = 0;
  int n_nal = 0;
  int n_checked = 0;
  int n_settings = 1;
  int stall_cycles = 0;

  h264_rtp_fu_a_fragmenter u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .nal_header(nal_header),
    .nal_length(nal_length),
    .last_of_frame(last_of_frame),
    .decode_time(decode_time),
    .composition_offset(composition_offset),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .prefix_present(prefix_present),
    .fu_indicator(fu_indicator),
    .fu_header(fu_header),
    .nal_offset(nal_offset),
    .nal_bytes(nal_bytes),
    .packet_bytes(packet_bytes),
    .marker_bit(marker_bit),
    .rtp_timestamp(rtp_timestamp),
    .last_packet(last_packet),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned eff_limit();
    return 32'((cfg_mtu < MTU_MIN) ? MTU_MIN : cfg_mtu);
  endfunction

  function automatic void predict_packets(input logic [7:0] hdr,
                                          input logic [NAL_LEN_W-1:0] len,
                                          input logic lof,
                                          input logic [TIME_W-1:0] dt,
                                          input logic [TIME_W-1:0] co);
    packet_t p;
    int unsigned lim;
    int unsigned chunk;
    int unsigned left;
    int unsigned off;
    logic [7:0] ind;
    logic [7:0] typ;
    logic [TIME_W-1:0] ts;
    lim = eff_limit();
    chunk = lim - 32'(PREFIX_LEN);
    ts = cfg_use_dt ? dt : dt + co;
    if (32'(len) <= lim) begin
      p = '{1'b0, 8'h00, 8'h00, 16'h0000, len, len, lof, ts, 1'b1};
      packet_q.push_back(p);
    end else begin
      ind = {hdr[7:5], FU_A_TYPE};
      typ = {3'b000, hdr[4:0]};
      off = 1;
      left = 32'(len) - 1;
      p = '{1'b1, ind, FU_START | typ, 16'(off), 16'(chunk),
            16'(chunk + 32'(PREFIX_LEN)), 1'b0, ts, 1'b0};
      packet_q.push_back(p);
      off += chunk;
      left -= chunk;
      while (left > chunk) begin
        p = '{1'b1, ind, typ, 16'(off), 16'(chunk), 16'(chunk + 32'(PREFIX_LEN)),
              1'b0, ts, 1'b0};
        packet_q.push_back(p);
        off += chunk;
        left -= chunk;
      end
      p = '{1'b1, ind, FU_END | typ, 16'(off), 16'(left), 16'(left + 32'(PREFIX_LEN)),
            lof, ts, 1'b1};
      packet_q.push_back(p);
    end
  endfunction

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] got);
    if (got !== exp_v) begin
      $error("%s: expected %0h, actual %0h", name, exp_v, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    packet_t exp_pkt;
    if (!rst && out_valid && out_ready) begin
      if (packet_q.size() == 0) begin
        $error("packet descriptor with no expected item pending");
        fail_count++;
      end else begin
        exp_pkt = packet_q.pop_front();
        n_checked++;
        check_field("prefix_present", 32'(exp_pkt.prefix), 32'(prefix_present));
        check_field("fu_indicator", 32'(exp_pkt.ind), 32'(fu_indicator));
        check_field("fu_header", 32'(exp_pkt.hdr), 32'(fu_header));
        check_field("nal_offset", 32'(exp_pkt.off), 32'(nal_offset));
        check_field("nal_bytes", 32'(exp_pkt.nbytes), 32'(nal_bytes));
        check_field("packet_bytes", 32'(exp_pkt.pbytes), 32'(packet_bytes));
        check_field("marker_bit", 32'(exp_pkt.marker), 32'(marker_bit));
        check_field("rtp_timestamp", exp_pkt.ts, rtp_timestamp);
        check_field("last_packet", 32'(exp_pkt.last), 32'(last_packet));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("** h264_rtp_fu_a_fragmenter: FAILED **");
      $finish;
    end
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else if (rx_idle && $urandom_range(0, 3) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(0, 9)) @(negedge clk);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  task automatic send_nal(input logic [7:0] hdr, input logic [NAL_LEN_W-1:0] len,
                          input logic lof, input logic [TIME_W-1:0] dt,
                          input logic [TIME_W-1:0] co);
    int gap;
    @(negedge clk);
    if (tx_idle && $urandom_range(0, 2) == 0) begin
      gap = $urandom_range(1, 10);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    nal_header = hdr;
    nal_length = len;
    last_of_frame = lof;
    decode_time = dt;
    composition_offset = co;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    predict_packets(hdr, len, lof, dt, co);
    n_nal++;
  endtask

  function automatic logic [NAL_LEN_W-1:0] pick_length();
    int unsigned lim;
    int unsigned chunk;
    int unsigned k;
    lim = eff_limit();
    chunk = lim - 32'(PREFIX_LEN);
    case ($urandom_range(0, 9))
      0, 1, 2: return 16'($urandom_range(0, lim));
      3: return 16'(lim - 1 + $urandom_range(0, 3));
      4: begin
        k = $urandom_range(1, 65533 / chunk);
        return 16'(k * chunk + $urandom_range(1, 2));
      end
      5, 6, 7: return 16'($urandom_range(lim + 1, lim + 10000));
      8: return 16'($urandom_range(0, 65535));
      default: return 16'(32'hffff - $urandom_range(0, 3));
    endcase
  endfunction

  task automatic send_random_nal();
    send_nal(8'($urandom_range(0, 255)), pick_length(), 1'($urandom_range(0, 1)),
             $urandom, $urandom);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MTU_W-1:0] data);
    @(negedge clk);
    cfg_index = idx;
    cfg_data = data;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_USE_DECODE_TIME: cfg_use_dt = data[0];
      CFG_MAX_PACKET_BYTES: cfg_mtu = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (packet_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_config(input logic use_dt, input logic [MTU_W-1:0] mtu);
    wait_idle();
    write_reg(CFG_USE_DECODE_TIME, {(MTU_W-1)'($urandom), use_dt});
    write_reg(CFG_MAX_PACKET_BYTES, mtu);
    n_settings++;
  endtask

  task automatic test_directed();
    int i;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    send_nal(8'h00, 16'd0, 1'b0, 32'h0, 32'h0);
    send_nal(8'hff, 16'd1, 1'b1, 32'hffffffff, 32'hffffffff);
    send_nal(8'h65, 16'(MTU_RESET), 1'b1, 32'h1234, 32'h10);
    send_nal(8'h65, 16'(MTU_RESET + 1), 1'b1, 32'h5678, 32'h0);
    send_nal(8'hfc, 16'(MTU_RESET + 2), 1'b0, $urandom, $urandom);
    send_nal(8'h7c, 16'(2 * (MTU_RESET - PREFIX_LEN) + 1), 1'b1, $urandom, $urandom);
    send_nal(8'h1f, 16'(2 * (MTU_RESET - PREFIX_LEN) + 2), 1'b1, $urandom, $urandom);
    send_nal(8'he0, 16'hffff, 1'b1, 32'h80000000, 32'h80000000);
    send_nal(8'h80, 16'hffff, 1'b0, $urandom, $urandom);
    send_nal(8'h41, 16'h8000, 1'b1, $urandom, $urandom);
    send_nal(8'h5c, 16'h7fff, 1'b0, $urandom, $urandom);
    for (i = 0; i < 8; i++) begin
      send_random_nal();
    end
  endtask

  task automatic test_config_sweep();
    logic use_dts[6] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
    logic [MTU_W-1:0] mtus[6] = '{14'd0, 14'd1099, MTU_MIN, 14'd9000, 14'd9001, 14'h3fff};
    int i;
    int lim;
    wait_idle();
    write_reg(CFG_UNUSED, 14'h3fff);
    for (i = 0; i < 6; i++) begin
      set_config(use_dts[i], mtus[i]);
      lim = eff_limit();
      send_nal(8'($urandom_range(0, 255)), 16'(lim), 1'b1, 32'hffffffff, 32'h1);
      send_nal(8'($urandom_range(0, 255)), 16'(lim + 1), 1'b1, $urandom, $urandom);
      send_nal(8'($urandom_range(0, 255)), 16'hffff, 1'($urandom_range(0, 1)),
               $urandom, $urandom);
      send_random_nal();
      send_random_nal();
    end
  endtask

  task automatic test_output_hold();
    int i;
    wait_idle();
    hold_req = 1'b1;
    for (i = 0; i < 5; i++) begin
      send_nal(8'($urandom_range(0, 255)), 16'($urandom_range(40000, 65535)), 1'b1,
               $urandom, $urandom);
    end
  endtask

  task automatic test_random_traffic();
    int ph;
    int i;
    logic [MTU_W-1:0] mtu;
    for (ph = 0; ph < 5; ph++) begin
      case ($urandom_range(0, 3))
        0: mtu = 14'($urandom_range(0, MTU_MIN - 1));
        1: mtu = 14'($urandom_range(9001, 16383));
        default: mtu = 14'($urandom_range(MTU_MIN, 9000));
      endcase
      set_config(1'($urandom_range(0, 1)), mtu);
      tx_idle = $urandom_range(0, 3) != 0;
      rx_idle = $urandom_range(0, 3) != 0;
      for (i = 0; i < 36; i++) begin
        send_random_nal();
      end
    end
  endtask

  task automatic test_final_burst();
    int i;
    set_config(1'($urandom_range(0, 1)), MTU_RESET);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    for (i = 0; i < 20; i++) begin
      send_random_nal();
    end
    wait_idle();
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    nal_header = '0;
    nal_length = '0;
    last_of_frame = 1'b0;
    decode_time = '0;
    composition_offset = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (11) @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_config_sweep();
    test_output_hold();
    test_random_traffic();
    test_final_burst();
    repeat (20) @(negedge clk);

    if (packet_q.size() != 0) begin
      $error("%0d packet descriptors never arrived", packet_q.size());
      fail_count++;
    end
    $display("Run covered %0d NAL units and %0d packet descriptors under %0d settings,",
             n_nal, n_checked, n_settings);
    $display("whole and fragmented units, idle gaps and a %0d-cycle output hold-off.",
             HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("** h264_rtp_fu_a_fragmenter: PASSED **");
    end else begin
      $display("** h264_rtp_fu_a_fragmenter: FAILED **");
    end
    $finish;
  end

endmodule
